[hdl/blm_pkg.sv]
// ----------------------------------------------------------------------------
// blm_pkg
// Shared types and constants of the battery level monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

   localparam int LEVEL_W   = 10;
   localparam int SAMPLE_W  = 10;
   localparam int OFFSET_W  = 8;
   localparam int HYST_W    = 8;
   localparam int GRADE_W   = 3;
   localparam int COUNT_W   = 5;
   localparam int SUM_W     = 14;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [SAMPLE_W-1:0] ADC_INVALID = 10'h3ff;
   localparam logic [LEVEL_W-1:0] SHOWN_RESET  = 10'd660;
   localparam logic [LEVEL_W-1:0] LATEST_RESET = 10'd1023;

   typedef enum logic [1:0] {
      MODE_SAMPLE     = 2'd0,
      MODE_PD_REQUEST = 2'd1,
      MODE_PD_POLL    = 2'd2,
      MODE_SYNC       = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESH_FULL   = 3'd0,
      CSR_THRESH_GRADE4 = 3'd1,
      CSR_THRESH_GRADE3 = 3'd2,
      CSR_THRESH_GRADE2 = 3'd3,
      CSR_THRESH_GRADE1 = 3'd4,
      CSR_PERMIT_LEVEL  = 3'd5,
      CSR_HYSTERESIS    = 3'd6,
      CSR_CHG_OFFSET    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] full;
      logic [LEVEL_W-1:0] grade4;
      logic [LEVEL_W-1:0] grade3;
      logic [LEVEL_W-1:0] grade2;
      logic [LEVEL_W-1:0] grade1;
   } thresh_type;

   typedef struct packed {
      logic                step;
      logic                dc_present;
      logic [SAMPLE_W-1:0] adc_sample;
      logic [OFFSET_W-1:0] charger_offset;
   } filt_cmd_type;

   typedef struct packed {
      logic               done;
      logic [LEVEL_W-1:0] average;
   } filt_stat_type;

endpackage

`default_nettype wire

[hdl/blm_req_if.sv]
// ----------------------------------------------------------------------------
// blm_req_if
// Input word channel: valid/ready handshake with mode, sample and charger flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface blm_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [blm_pkg::SAMPLE_W-1:0]  adc_sample;
   logic                          dc_present;

   modport source (output valid, output mode, output adc_sample, output dc_present,
                   input ready);
   modport sink   (input valid, input mode, input adc_sample, input dc_present,
                   output ready);
endinterface

`default_nettype wire

[hdl/blm_rsp_if.sv]
// ----------------------------------------------------------------------------
// blm_rsp_if
// Result word channel: valid/ready handshake with levels, grades and flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface blm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [blm_pkg::LEVEL_W-1:0]  shown_level;
   logic [blm_pkg::LEVEL_W-1:0]  current_level;
   logic [blm_pkg::GRADE_W-1:0]  shown_grade;
   logic [blm_pkg::GRADE_W-1:0]  current_grade;
   logic                         permit_run;
   logic                         average_done;
   logic                         sample_rejected;
   logic                         power_down_now;

   modport source (output valid, output shown_level, output current_level,
                   output shown_grade, output current_grade, output permit_run,
                   output average_done, output sample_rejected, output power_down_now,
                   input ready);
   modport sink   (input valid, input shown_level, input current_level,
                   input shown_grade, input current_grade, input permit_run,
                   input average_done, input sample_rejected, input power_down_now,
                   output ready);
endinterface

`default_nettype wire

[hdl/battery_level_monitor_core.sv]
// ----------------------------------------------------------------------------
// battery_level_monitor_core
// Trimmed-mean battery level filter with hysteresis, grading and power-down.
// ----------------------------------------------------------------------------
// Takes one word per clock while the result channel does not stall, and
// returns one result word for each, in order. A word is captured in an
// input register, processed combinationally (offset, batch sum/min/max,
// trimmed mean by reciprocal multiply, hysteresis and power-down latch) and
// written to a result register. Grades are formed from the result register
// against the threshold registers. The user must write registers through
// the csr port only while no word is in flight; the block itself does not
// enforce it. No clearing pass is needed after reset.
`default_nettype none

module battery_level_monitor_core #(
   parameter int BATCH_SIZE = 6
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   blm_req_if.sink                                req_chan,
   blm_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_wr_en,
   input  wire logic [blm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [blm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // configuration registers
   blm_pkg::thresh_type           thresh_ff;
   logic [blm_pkg::LEVEL_W-1:0]   permit_level_ff;
   logic [blm_pkg::HYST_W-1:0]    hyst_ff;
   logic [blm_pkg::OFFSET_W-1:0]  offset_ff;

   // input register
   logic                          in_valid_ff;
   logic [1:0]                    mode_ff;
   logic [blm_pkg::SAMPLE_W-1:0]  adc_ff;
   logic                          dc_ff;

   // level state
   logic [blm_pkg::LEVEL_W-1:0]   shown_ff, shown_in;
   logic [blm_pkg::LEVEL_W-1:0]   latest_ff, latest_in;
   logic                          pending_ff, pending_in;

   // result register
   logic                          rsp_valid_ff;
   logic [blm_pkg::LEVEL_W-1:0]   rsp_shown_ff, rsp_current_ff;
   logic                          rsp_permit_ff, rsp_done_ff, rsp_reject_ff, rsp_pdn_ff;

   logic                          move;
   logic                          rejected, pdn_now, permit_old;
   logic [blm_pkg::LEVEL_W:0]     diff;
   blm_pkg::filt_cmd_type         filt_cmd;
   blm_pkg::filt_stat_type        filt_stat;

   assign move           = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || move;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.full   <= 10'd700;
         thresh_ff.grade4 <= 10'd660;
         thresh_ff.grade3 <= 10'd640;
         thresh_ff.grade2 <= 10'd620;
         thresh_ff.grade1 <= 10'd600;
         permit_level_ff  <= 10'd610;
         hyst_ff          <= 8'd8;
         offset_ff        <= 8'd16;
      end else if (csr_wr_en) begin
         case (blm_pkg::csr_index_type'(csr_index))
            blm_pkg::CSR_THRESH_FULL:   thresh_ff.full   <= csr_wdata;
            blm_pkg::CSR_THRESH_GRADE4: thresh_ff.grade4 <= csr_wdata;
            blm_pkg::CSR_THRESH_GRADE3: thresh_ff.grade3 <= csr_wdata;
            blm_pkg::CSR_THRESH_GRADE2: thresh_ff.grade2 <= csr_wdata;
            blm_pkg::CSR_THRESH_GRADE1: thresh_ff.grade1 <= csr_wdata;
            blm_pkg::CSR_PERMIT_LEVEL:  permit_level_ff  <= csr_wdata;
            blm_pkg::CSR_HYSTERESIS:    hyst_ff          <= csr_wdata[blm_pkg::HYST_W-1:0];
            blm_pkg::CSR_CHG_OFFSET:    offset_ff        <= csr_wdata[blm_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         mode_ff <= req_chan.mode;
         adc_ff  <= req_chan.adc_sample;
         dc_ff   <= req_chan.dc_present;
      end
   end

   assign rejected = (blm_pkg::mode_type'(mode_ff) == blm_pkg::MODE_SAMPLE)
                     && (adc_ff == blm_pkg::ADC_INVALID);

   always_comb begin
      filt_cmd.step           = move && !rejected
                                && (blm_pkg::mode_type'(mode_ff) == blm_pkg::MODE_SAMPLE);
      filt_cmd.dc_present     = dc_ff;
      filt_cmd.adc_sample     = adc_ff;
      filt_cmd.charger_offset = offset_ff;
   end

   blm_filter #(
      .BATCH_SIZE (BATCH_SIZE)
   ) u_filter (
      .clock (clock),
      .reset (reset),
      .cmd   (filt_cmd),
      .stat  (filt_stat)
   );

   always_comb begin
      permit_old = dc_ff || (shown_ff >= permit_level_ff);
      diff = (shown_ff > filt_stat.average)
             ? {1'b0, shown_ff} - {1'b0, filt_stat.average}
             : {1'b0, filt_stat.average} - {1'b0, shown_ff};
      shown_in   = shown_ff;
      latest_in  = latest_ff;
      pending_in = pending_ff;
      pdn_now    = 1'b0;
      case (blm_pkg::mode_type'(mode_ff))
         blm_pkg::MODE_SAMPLE: begin
            if (filt_stat.done) begin
               latest_in = filt_stat.average;
               if (diff > {3'b000, hyst_ff}) begin
                  shown_in = filt_stat.average;
               end
            end
         end
         blm_pkg::MODE_PD_REQUEST: begin
            if (!permit_old) begin
               pending_in = 1'b1;
            end
         end
         blm_pkg::MODE_PD_POLL: begin
            if (!permit_old && pending_ff) begin
               pending_in = 1'b0;
               pdn_now    = 1'b1;
            end
         end
         blm_pkg::MODE_SYNC: begin
            shown_in = latest_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff   <= blm_pkg::SHOWN_RESET;
         latest_ff  <= blm_pkg::LATEST_RESET;
         pending_ff <= 1'b0;
      end else if (move) begin
         shown_ff   <= shown_in;
         latest_ff  <= latest_in;
         pending_ff <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_shown_ff   <= shown_in;
         rsp_current_ff <= latest_in;
         rsp_permit_ff  <= dc_ff || (shown_in >= permit_level_ff);
         rsp_done_ff    <= filt_stat.done;
         rsp_reject_ff  <= rejected;
         rsp_pdn_ff     <= pdn_now;
      end
   end

   blm_grade u_shown_grade (
      .level  (rsp_shown_ff),
      .thresh (thresh_ff),
      .grade  (rsp_chan.shown_grade)
   );

   blm_grade u_current_grade (
      .level  (rsp_current_ff),
      .thresh (thresh_ff),
      .grade  (rsp_chan.current_grade)
   );

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.shown_level     = rsp_shown_ff;
   assign rsp_chan.current_level   = rsp_current_ff;
   assign rsp_chan.permit_run      = rsp_permit_ff;
   assign rsp_chan.average_done    = rsp_done_ff;
   assign rsp_chan.sample_rejected = rsp_reject_ff;
   assign rsp_chan.power_down_now  = rsp_pdn_ff;

   a_done_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_done_ff && rsp_reject_ff))
      else $error("result flags both average and rejection");

   a_pdn_not_permitted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_pdn_ff) |-> !rsp_permit_ff)
      else $error("power-down reported while run permitted");

   a_sync_levels: assert property (@(posedge clock) disable iff (reset)
      (move && (blm_pkg::mode_type'(mode_ff) == blm_pkg::MODE_SYNC))
      |=> (rsp_shown_ff == rsp_current_ff))
      else $error("sync left shown and current levels apart");

   a_pdn_clears_latch: assert property (@(posedge clock) disable iff (reset)
      (move && pdn_now) |=> !pending_ff)
      else $error("power-down latch kept after firing");

endmodule

`default_nettype wire

[hdl/blm_grade.sv]
// ----------------------------------------------------------------------------
// blm_grade
// Grades a level 0 to 5 against five thresholds, highest grade tested first.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_grade (
   input  wire logic [blm_pkg::LEVEL_W-1:0] level,
   input  wire blm_pkg::thresh_type         thresh,
   output logic      [blm_pkg::GRADE_W-1:0] grade
);

   always_comb begin
      if (level >= thresh.full) begin
         grade = 3'd5;
      end else if (level >= thresh.grade4) begin
         grade = 3'd4;
      end else if (level >= thresh.grade3) begin
         grade = 3'd3;
      end else if (level >= thresh.grade2) begin
         grade = 3'd2;
      end else if (level >= thresh.grade1) begin
         grade = 3'd1;
      end else begin
         grade = 3'd0;
      end
   end

endmodule

`default_nettype wire

[hdl/blm_filter.sv]
// ----------------------------------------------------------------------------
// blm_filter
// Batch accumulator: charger offset, running sum, min and max, and the
// trimmed mean at the end of each batch.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_filter #(
   parameter int BATCH_SIZE = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire blm_pkg::filt_cmd_type  cmd,
   output blm_pkg::filt_stat_type      stat
);

   localparam int DIVISOR     = BATCH_SIZE - 2;
   // exact for every 14-bit dividend while divisor stays below 16
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP       = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
   localparam int PROD_W      = blm_pkg::SUM_W + RECIP_W;

   logic [blm_pkg::COUNT_W-1:0]  count_ff, count_in, count_inc;
   logic [blm_pkg::SUM_W-1:0]    sum_ff, sum_in, sum_new, trimmed;
   logic [blm_pkg::SAMPLE_W-1:0] min_ff, min_in, min_new;
   logic [blm_pkg::SAMPLE_W-1:0] max_ff, max_in, max_new;
   logic [blm_pkg::SAMPLE_W-1:0] sample;
   logic [PROD_W-1:0]            product;
   logic                         batch_end;

   always_comb begin
      sample = cmd.adc_sample;
      if (cmd.dc_present) begin
         if (cmd.adc_sample > {2'b00, cmd.charger_offset}) begin
            sample = cmd.adc_sample - {2'b00, cmd.charger_offset};
         end else begin
            sample = '0;
         end
      end

      sum_new   = sum_ff + {{(blm_pkg::SUM_W-blm_pkg::SAMPLE_W){1'b0}}, sample};
      min_new   = (sample < min_ff) ? sample : min_ff;
      max_new   = (sample > max_ff) ? sample : max_ff;
      count_inc = count_ff + blm_pkg::COUNT_W'(1);
      batch_end = (count_inc >= blm_pkg::COUNT_W'(BATCH_SIZE));

      trimmed = sum_new - {{(blm_pkg::SUM_W-blm_pkg::SAMPLE_W){1'b0}}, min_new}
                        - {{(blm_pkg::SUM_W-blm_pkg::SAMPLE_W){1'b0}}, max_new};
      // divide by the batch size less two through a reciprocal multiply
      product = {{RECIP_W{1'b0}}, trimmed} * {{blm_pkg::SUM_W{1'b0}}, RECIP_W'(RECIP)};

      stat.done    = cmd.step && batch_end;
      stat.average = product[RECIP_SHIFT +: blm_pkg::LEVEL_W];

      count_in = count_ff;
      sum_in   = sum_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      if (cmd.step) begin
         if (batch_end) begin
            count_in = '0;
            sum_in   = '0;
            min_in   = blm_pkg::ADC_INVALID;
            max_in   = '0;
         end else begin
            count_in = count_inc;
            sum_in   = sum_new;
            min_in   = min_new;
            max_in   = max_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         min_ff   <= blm_pkg::ADC_INVALID;
         max_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
      end
   end

   a_count_in_batch: assert property (@(posedge clock) disable iff (reset)
      count_ff < blm_pkg::COUNT_W'(BATCH_SIZE))
      else $error("sample count past batch size");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (count_ff == '0) && (sum_ff == '0))
      else $error("batch state not cleared after average");

endmodule

`default_nettype wire
